// ===== design/cau_pkg.sv =====
// Shared constants, opcodes and sequencer states for the complex arithmetic unit.
package cau_pkg;

  localparam int WORD_BITS_D = 32;
  localparam int FRAC_BITS_D = 16;
  localparam int EXP_BITS_D  = 8;
  localparam int CMD_BITS    = 4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_NEG   = 4'd4,
    CMD_POW   = 4'd5,
    CMD_MAG   = 4'd6,
    CMD_SQRT  = 4'd7,
    CMD_EQUAL = 4'd8
  } cau_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_ITA_GO,
    ST_ITA_WAIT,
    ST_ITB_GO,
    ST_ITB_WAIT,
    ST_ITC_GO,
    ST_ITC_WAIT,
    ST_OUT
  } cau_state_t;

endpackage

// ===== design/cau_if.sv =====
// Request and response channel interfaces of the complex arithmetic unit.
interface cau_req_if #(
  parameter int W = cau_pkg::WORD_BITS_D,
  parameter int E = cau_pkg::EXP_BITS_D
) ();
  logic                          valid;
  logic                          ready;
  logic [cau_pkg::CMD_BITS-1:0]  cmd;
  logic signed [W-1:0]           a_re;
  logic signed [W-1:0]           a_im;
  logic signed [W-1:0]           b_re;
  logic signed [W-1:0]           b_im;
  logic [E-1:0]                  power_exp;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, power_exp, input ready);
  modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, power_exp, output ready);
endinterface

interface cau_rsp_if #(
  parameter int W = cau_pkg::WORD_BITS_D
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_re;
  logic signed [W-1:0] res_im;
  logic                flag;

  modport source (output valid, res_re, res_im, flag, input ready);
  modport sink   (input valid, res_re, res_im, flag, output ready);
endinterface

// ===== design/cau_mul.sv =====
// Shared unsigned multiplier with registered product.
module cau_mul #(
  parameter int W = cau_pkg::WORD_BITS_D
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
  end

endmodule

// ===== design/cau_iter.sv =====
// Shared shift/compare/subtract unit: restoring divide or bit-pair square root.
module cau_iter #(
  parameter int W = cau_pkg::WORD_BITS_D,
  parameter int F = cau_pkg::FRAC_BITS_D
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           mode_sqrt,
  input  logic [2*W-1:0] x,
  input  logic [2*W-1:0] den,
  output logic [W:0]     result,
  output logic           done
);

  localparam int NW = 2*W + F;
  localparam int RW = 2*W + 2;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] src;
  logic [RW-1:0] rem;
  logic [W-1:0]  acc;
  logic          ovf;
  logic          mode_r;
  logic [2*W-1:0] den_r;

  logic [RW-1:0] shifted;
  logic [RW-1:0] opnd;
  logic          ge;

  always_comb begin
    if (mode_r) begin
      shifted = {rem[RW-3:0], src[NW-1:NW-2]};
      opnd    = {{(RW-W-2){1'b0}}, acc, 2'b01};
    end else begin
      shifted = {rem[RW-2:0], src[NW-1]};
      opnd    = {2'b00, den_r};
    end
    ge = (shifted >= opnd);
  end

  assign result = {ovf, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        src    <= {x, {F{1'b0}}};
        rem    <= '0;
        acc    <= '0;
        ovf    <= 1'b0;
        mode_r <= mode_sqrt;
        den_r  <= den;
        cnt    <= mode_sqrt ? CW'(W) : CW'(NW);
      end else if (busy) begin
        rem <= ge ? (shifted - opnd) : shifted;
        acc <= {acc[W-2:0], ge};
        // quotient bits that leave the word mark saturation
        ovf <= ovf | acc[W-1];
        src <= mode_r ? {src[NW-3:0], 2'b00} : {src[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: sequencer, operand registers and result word.
//
//  channel | interface    | word
//  --------+--------------+------------------------------------------------
//  req     | cau_req_if   | cmd, a_re, a_im, b_re, b_im, power_exp
//  rsp     | cau_rsp_if   | res_re, res_im, flag
//
// One word at a time: req.ready is high only while idle, rsp.valid holds until taken.
// Sequencing per word:
//   add, sub, neg, equal, div by zero, pow 0/1: the simple step only;
//   mul and pow e: the single shared multiplier, pow repeating the multiply up to power e;
//   div, magnitude, sqrt: squares on the same multiplier, then
//   the bit-serial divide/square-root unit.
// Reset (rst, synchronous) returns the sequencer to idle; no clearing pass.
// A stalled rsp simply holds the result word and keeps req.ready low.
module complex_arithmetic_unit #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_D,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_D,
  parameter int EXP_BITS  = cau_pkg::EXP_BITS_D
) (
  input logic     clk,
  input logic     rst,
  cau_req_if.sink req,
  cau_rsp_if.source rsp
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int E = EXP_BITS;

  localparam logic [2*W-1:0] WSIGN_X = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] WMAX_X  = WSIGN_X - 1'b1;
  localparam logic [2*W-1:0] ONE_X   = {{(2*W-1){1'b0}}, 1'b1} << F;
  localparam logic [W-1:0]   WMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   WMIN    = {1'b1, {(W-1){1'b0}}};

  // ---- helpers ----
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // sign/magnitude to word, saturating
  function automatic logic [W-1:0] to_word(input logic neg, input logic [2*W-1:0] m);
    if (!neg) begin
      return (m > WMAX_X) ? WMAX : m[W-1:0];
    end
    return (m >= WSIGN_X) ? WMIN : (~m[W-1:0] + 1'b1);
  endfunction

  function automatic logic [W-1:0] sat1(input logic [W:0] s);
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  // signed-magnitude add, result {sign, magnitude}
  function automatic logic [2*W:0] smadd(input logic sa, input logic [2*W-1:0] ma,
                                         input logic sb, input logic [2*W-1:0] mb);
    logic           s;
    logic [2*W-1:0] m;
    if (sa == sb) begin
      s = sa;
      m = ma + mb;
    end else if (ma >= mb) begin
      s = sa;
      m = ma - mb;
    end else begin
      s = sb;
      m = mb - ma;
    end
    if (m == '0) s = 1'b0;
    return {s, m};
  endfunction

  // ---- state ----
  cau_pkg::cau_state_t state, state_next;

  logic [cau_pkg::CMD_BITS-1:0] cmd_r;
  logic [W-1:0]   cr, ci, br, bi;   // cr/ci: a, or the running power; br/bi: second factor
  logic [E-1:0]   e_r, cnt;
  logic [2*W-1:0] p0, p1, p2, q0, den;
  logic           nre_s, nim_s;
  logic [2*W-1:0] nre_m, nim_m;
  logic [W-1:0]   am;
  logic [W-1:0]   rr, ri;
  logic           flg;

  logic           accept;
  logic           is_div;
  logic [E-1:0]   cnt_inc;

  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] prod;

  logic           it_start, it_sqrt, it_done;
  logic [2*W-1:0] it_x;
  logic [W:0]     it_res;

  logic [2*W:0]   sum_re, sum_im;
  logic [W+1:0]   t1w, t2w;
  logic [W-1:0]   th1, th2;
  logic [2*W-1:0] arg1, arg2;
  logic [W:0]     s_add, s_sub, s_neg;

  assign accept  = req.valid && req.ready;
  assign is_div  = (cmd_r == cau_pkg::CMD_DIV);
  assign cnt_inc = cnt + 1'b1;

  cau_mul #(.W(W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cau_iter #(.W(W), .F(F)) u_iter (
    .clk       (clk),
    .rst       (rst),
    .start     (it_start),
    .mode_sqrt (it_sqrt),
    .x         (it_x),
    .den       (den),
    .result    (it_res),
    .done      (it_done)
  );

  // ---- datapath arithmetic ----
  always_comb begin
    // re: dot(c, y) with second term negated for mul; im: negated for div
    sum_re = smadd(cr[W-1] ^ br[W-1], p0, ci[W-1] ^ bi[W-1] ^ !is_div, p1);
    sum_im = smadd(ci[W-1] ^ br[W-1], p2, cr[W-1] ^ bi[W-1] ^ is_div, prod);

    // sqrt half-angle arguments, clamped at zero
    t1w  = {2'b00, am} + {{2{cr[W-1]}}, cr};
    t2w  = {2'b00, am} - {{2{cr[W-1]}}, cr};
    th1  = t1w[W+1] ? '0 : t1w[W:1];
    th2  = t2w[W+1] ? '0 : t2w[W:1];
    arg1 = {{W{1'b0}}, th1} << F;
    arg2 = {{W{1'b0}}, th2} << F;

    s_add = {cr[W-1], cr} + {br[W-1], br};
    s_sub = {cr[W-1], cr} - {br[W-1], br};
    s_neg = '0 - {cr[W-1], cr};
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      cau_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.cmd)
            cau_pkg::CMD_MUL: state_next = cau_pkg::ST_M0;
            cau_pkg::CMD_DIV: state_next = (req.b_re == '0 && req.b_im == '0) ?
                                           cau_pkg::ST_SIMPLE : cau_pkg::ST_SQ0;
            cau_pkg::CMD_POW: state_next = (req.power_exp <= E'(1)) ?
                                           cau_pkg::ST_SIMPLE : cau_pkg::ST_M0;
            cau_pkg::CMD_MAG,
            cau_pkg::CMD_SQRT: state_next = cau_pkg::ST_SQ0;
            default: state_next = cau_pkg::ST_SIMPLE;
          endcase
        end
      end
      cau_pkg::ST_SIMPLE: state_next = cau_pkg::ST_OUT;
      cau_pkg::ST_SQ0:    state_next = cau_pkg::ST_SQ1;
      cau_pkg::ST_SQ1:    state_next = cau_pkg::ST_SQ2;
      cau_pkg::ST_SQ2:    state_next = is_div ? cau_pkg::ST_M0 : cau_pkg::ST_ITA_GO;
      cau_pkg::ST_M0:     state_next = cau_pkg::ST_M1;
      cau_pkg::ST_M1:     state_next = cau_pkg::ST_M2;
      cau_pkg::ST_M2:     state_next = cau_pkg::ST_M3;
      cau_pkg::ST_M3:     state_next = cau_pkg::ST_M4;
      cau_pkg::ST_M4: begin
        if (cmd_r == cau_pkg::CMD_POW && cnt_inc != e_r) state_next = cau_pkg::ST_M0;
        else if (is_div) state_next = cau_pkg::ST_ITA_GO;
        else state_next = cau_pkg::ST_OUT;
      end
      cau_pkg::ST_ITA_GO: state_next = cau_pkg::ST_ITA_WAIT;
      cau_pkg::ST_ITA_WAIT: begin
        if (it_done) begin
          state_next = (cmd_r == cau_pkg::CMD_MAG) ? cau_pkg::ST_OUT : cau_pkg::ST_ITB_GO;
        end
      end
      cau_pkg::ST_ITB_GO: state_next = cau_pkg::ST_ITB_WAIT;
      cau_pkg::ST_ITB_WAIT: begin
        if (it_done) state_next = is_div ? cau_pkg::ST_OUT : cau_pkg::ST_ITC_GO;
      end
      cau_pkg::ST_ITC_GO: state_next = cau_pkg::ST_ITC_WAIT;
      cau_pkg::ST_ITC_WAIT: begin
        if (it_done) state_next = cau_pkg::ST_OUT;
      end
      cau_pkg::ST_OUT: begin
        if (rsp.ready) state_next = cau_pkg::ST_IDLE;
      end
      default: state_next = cau_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    req.ready = (state == cau_pkg::ST_IDLE);
    rsp.valid = (state == cau_pkg::ST_OUT);
    mul_a     = mag(cr);
    mul_b     = mag(br);
    it_start  = 1'b0;
    it_sqrt   = 1'b1;
    it_x      = den;
    case (state)
      cau_pkg::ST_M1: begin
        mul_a = mag(ci);
        mul_b = mag(bi);
      end
      cau_pkg::ST_M2: begin
        mul_a = mag(ci);
        mul_b = mag(br);
      end
      cau_pkg::ST_M3: begin
        mul_a = mag(cr);
        mul_b = mag(bi);
      end
      cau_pkg::ST_SQ0: begin
        mul_a = mag(br);
        mul_b = mag(br);
      end
      cau_pkg::ST_SQ1: begin
        mul_a = mag(bi);
        mul_b = mag(bi);
      end
      cau_pkg::ST_ITA_GO: begin
        it_start = 1'b1;
        it_sqrt  = !is_div;
        it_x     = is_div ? nre_m : den;
      end
      cau_pkg::ST_ITB_GO: begin
        it_start = 1'b1;
        it_sqrt  = !is_div;
        it_x     = is_div ? nim_m : arg1;
      end
      cau_pkg::ST_ITC_GO: begin
        it_start = 1'b1;
        it_x     = arg2;
      end
      default: ;
    endcase
  end

  assign rsp.res_re = rr;
  assign rsp.res_im = ri;
  assign rsp.flag   = flg;

  always_ff @(posedge clk) begin
    if (rst) state <= cau_pkg::ST_IDLE;
    else state <= state_next;
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state)
      cau_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_r <= req.cmd;
          cr    <= req.a_re;
          ci    <= req.a_im;
          // pow multiplies by a; magnitude and sqrt square a
          if (req.cmd == cau_pkg::CMD_POW || req.cmd == cau_pkg::CMD_MAG ||
              req.cmd == cau_pkg::CMD_SQRT) begin
            br <= req.a_re;
            bi <= req.a_im;
          end else begin
            br <= req.b_re;
            bi <= req.b_im;
          end
          e_r <= req.power_exp;
          cnt <= E'(1);
          rr  <= '0;
          ri  <= '0;
          flg <= 1'b0;
        end
      end
      cau_pkg::ST_SIMPLE: begin
        case (cmd_r)
          cau_pkg::CMD_ADD: begin
            rr <= sat1(s_add);
            ri <= sat1({ci[W-1], ci} + {bi[W-1], bi});
          end
          cau_pkg::CMD_SUB: begin
            rr <= sat1(s_sub);
            ri <= sat1({ci[W-1], ci} - {bi[W-1], bi});
          end
          cau_pkg::CMD_NEG: begin
            rr <= sat1(s_neg);
            ri <= sat1('0 - {ci[W-1], ci});
          end
          cau_pkg::CMD_DIV:   flg <= 1'b1;  // only divide by zero lands here
          cau_pkg::CMD_POW: begin
            if (e_r == '0) begin
              rr <= to_word(1'b0, ONE_X);
            end else begin
              rr <= cr;
              ri <= ci;
            end
          end
          cau_pkg::CMD_EQUAL: flg <= (cr == br) && (ci == bi);
          default: ;
        endcase
      end
      cau_pkg::ST_SQ1: q0 <= prod;
      cau_pkg::ST_SQ2: den <= q0 + prod;
      cau_pkg::ST_M1:  p0 <= prod;
      cau_pkg::ST_M2:  p1 <= prod;
      cau_pkg::ST_M3:  p2 <= prod;
      cau_pkg::ST_M4: begin
        if (is_div) begin
          nre_s <= sum_re[2*W];
          nre_m <= sum_re[2*W-1:0];
          nim_s <= sum_im[2*W];
          nim_m <= sum_im[2*W-1:0];
        end else begin
          rr  <= to_word(sum_re[2*W], sum_re[2*W-1:0] >> F);
          ri  <= to_word(sum_im[2*W], sum_im[2*W-1:0] >> F);
          cr  <= to_word(sum_re[2*W], sum_re[2*W-1:0] >> F);
          ci  <= to_word(sum_im[2*W], sum_im[2*W-1:0] >> F);
          cnt <= cnt_inc;
        end
      end
      cau_pkg::ST_ITA_WAIT: begin
        if (it_done) begin
          if (is_div) rr <= to_word(nre_s, {{(W-1){1'b0}}, it_res});
          else if (cmd_r == cau_pkg::CMD_MAG) rr <= to_word(1'b0, {{(W-1){1'b0}}, it_res});
          else am <= it_res[W-1:0];
        end
      end
      cau_pkg::ST_ITB_WAIT: begin
        if (it_done) begin
          if (is_div) ri <= to_word(nim_s, {{(W-1){1'b0}}, it_res});
          else rr <= to_word(1'b0, {{(W-1){1'b0}}, it_res});
        end
      end
      cau_pkg::ST_ITC_WAIT: begin
        if (it_done) ri <= to_word(ci[W-1], {{(W-1){1'b0}}, it_res});
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // one word in flight: never ready for a new word while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request taken while a result word is pending");

  // the iterative unit only finishes while the sequencer waits on it
  a_iter_done_wait: assert property (@(posedge clk) disable iff (rst)
    it_done |-> (state == cau_pkg::ST_ITA_WAIT || state == cau_pkg::ST_ITB_WAIT ||
                 state == cau_pkg::ST_ITC_WAIT))
    else $error("iterative unit finished outside a wait state");

  // flag is only ever raised by divide or equal
  a_flag_cmd: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.flag) |-> (cmd_r == cau_pkg::CMD_DIV || cmd_r == cau_pkg::CMD_EQUAL))
    else $error("flag raised for an opcode that never sets it");
`endif

endmodule

// ===== tb/sv/tb_complex_arithmetic_unit.sv =====
// Self-checking testbench for complex_arithmetic_unit: bit-exact predictor and response scoreboard.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int W = WORD_BITS_D;
  localparam int F = FRAC_BITS_D;
  localparam int E = EXP_BITS_D;

  typedef bit [63:0] u64_t;

  localparam longint WMAX = (longint'(1) <<< (W - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam u64_t   WSIGN = u64_t'(1) << (W - 1);
  localparam logic [W-1:0] MOST_POS = WMAX[W-1:0];
  localparam logic [W-1:0] MOST_NEG = WMIN[W-1:0];
  localparam logic [W-1:0] UNITY = W'(1) << F;
  localparam logic [CMD_BITS-1:0] CMD_TOP = {CMD_BITS{1'b1}};

  // one request word
  typedef struct {
    logic [CMD_BITS-1:0] cmd;
    logic [W-1:0]        a_re, a_im, b_re, b_im;
    logic [E-1:0]        power_exp;
  } op_t;

  // one response word
  typedef struct {
    logic [W-1:0] re, im;
    logic         flag;
  } res_t;

  logic clk;
  logic rst;

  cau_req_if req ();
  cau_rsp_if rsp ();

  complex_arithmetic_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  res_t pending_results[$];
  int   errors;
  bit   idle_on;      // random bursts of idling on both sides
  bit   hold_rsp;     // ask the receiver for one long stall
  int   hold_cycles;
  int   rsp_burst;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Sign-magnitude 64-bit arithmetic, truncation toward zero,
  // saturation on the way back into a word.
  // ---------------------------------------------------------------------------
  function automatic u64_t umag(longint x);
    return x < 0 ? u64_t'(-x) : u64_t'(x);
  endfunction

  function automatic longint clamp_word(bit neg, u64_t m);
    if (!neg) return (m > u64_t'(WMAX)) ? WMAX : longint'(m);
    if (m >= WSIGN) return WMIN;
    return -longint'(m);
  endfunction

  function automatic longint sat_word(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  // x*y +/- u*v as sign and magnitude; a zero magnitude is positive
  function automatic void cross_sum(longint x, longint y, longint u, longint v, bit minus,
                                    output bit s, output u64_t m);
    bit   s1, s2;
    u64_t m1, m2;
    s1 = (x < 0) != (y < 0);
    s2 = ((u < 0) != (v < 0)) != minus;
    m1 = umag(x) * umag(y);
    m2 = umag(u) * umag(v);
    if (s1 == s2) begin s = s1; m = m1 + m2; end
    else if (m1 >= m2) begin s = s1; m = m1 - m2; end
    else begin s = s2; m = m2 - m1; end
    if (m == 0) s = 1'b0;
  endfunction

  function automatic void fx_cmul(longint ar, longint ai, longint br, longint bi,
                                  output longint rr, output longint ri);
    bit   s;
    u64_t m;
    cross_sum(ar, br, ai, bi, 1'b1, s, m);
    rr = clamp_word(s, m >> F);
    cross_sum(ai, br, ar, bi, 1'b0, s, m);
    ri = clamp_word(s, m >> F);
  endfunction

  // restoring division: integer part then F fraction bits
  function automatic longint fx_quot(bit s, u64_t num, u64_t den);
    u64_t q, r;
    q = num / den;
    r = num % den;
    if (q > WSIGN) return clamp_word(s, WSIGN + 1);
    for (int k = 0; k < F; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin r = r - den; q[0] = 1'b1; end
    end
    return clamp_word(s, q);
  endfunction

  function automatic u64_t floor_sqrt(u64_t x);
    u64_t r, b;
    r = 0;
    b = u64_t'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin x = x - (r + b); r = (r >> 1) + b; end
      else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic res_t predict_result(op_t op);
    res_t   res;
    longint ar, ai, br, bi, rr, ri, tr, ti, t;
    u64_t   m, den, am;
    bit     s, flg;
    ar = longint'(signed'(op.a_re));
    ai = longint'(signed'(op.a_im));
    br = longint'(signed'(op.b_re));
    bi = longint'(signed'(op.b_im));
    rr = 0;
    ri = 0;
    flg = 1'b0;
    case (op.cmd)
      CMD_ADD: begin rr = sat_word(ar + br); ri = sat_word(ai + bi); end
      CMD_SUB: begin rr = sat_word(ar - br); ri = sat_word(ai - bi); end
      CMD_MUL: fx_cmul(ar, ai, br, bi, rr, ri);
      CMD_DIV: begin
        if (br == 0 && bi == 0) begin
          flg = 1'b1;
        end else begin
          den = umag(br) * umag(br) + umag(bi) * umag(bi);
          cross_sum(ar, br, ai, bi, 1'b0, s, m);
          rr = fx_quot(s, m, den);
          cross_sum(ai, br, ar, bi, 1'b1, s, m);
          ri = fx_quot(s, m, den);
        end
      end
      CMD_NEG: begin rr = sat_word(-ar); ri = sat_word(-ai); end
      CMD_POW: begin
        if (op.power_exp == 0) begin
          rr = clamp_word(1'b0, u64_t'(1) << F);
        end else begin
          rr = ar;
          ri = ai;
          for (int k = 1; k < op.power_exp; k++) begin
            fx_cmul(rr, ri, ar, ai, tr, ti);
            rr = tr;
            ri = ti;
          end
        end
      end
      CMD_MAG: begin
        am = floor_sqrt(umag(ar) * umag(ar) + umag(ai) * umag(ai));
        rr = clamp_word(1'b0, am);
      end
      CMD_SQRT: begin
        am = floor_sqrt(umag(ar) * umag(ar) + umag(ai) * umag(ai));
        t = longint'(am) + ar;
        if (t < 0) t = 0;
        rr = clamp_word(1'b0, floor_sqrt((u64_t'(t) >> 1) << F));
        t = longint'(am) - ar;
        if (t < 0) t = 0;
        ri = clamp_word(ai < 0, floor_sqrt((u64_t'(t) >> 1) << F));
      end
      CMD_EQUAL: flg = (ar == br) && (ai == bi);
      default: ;
    endcase
    res.re = rr[W-1:0];
    res.im = ri[W-1:0];
    res.flag = flg;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one word per call, optional random gap first.
  // ---------------------------------------------------------------------------
  task automatic send_word(op_t op);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.cmd       <= op.cmd;
    req.a_re      <= op.a_re;
    req.a_im      <= op.a_im;
    req.b_re      <= op.b_re;
    req.b_im      <= op.b_im;
    req.power_exp <= op.power_exp;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(predict_result(op));
  endtask

  task automatic send_fields(logic [CMD_BITS-1:0] cmd, logic [W-1:0] ar, logic [W-1:0] ai,
                             logic [W-1:0] br, logic [W-1:0] bi, logic [E-1:0] pe);
    op_t op;
    op.cmd = cmd;
    op.a_re = ar;
    op.a_im = ai;
    op.b_re = br;
    op.b_im = bi;
    op.power_exp = pe;
    send_word(op);
  endtask

  // sender pause: drop valid and let every outstanding result drain
  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // operand mix: extremes, values near 1.0, small and full-range random
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MOST_POS;
      1: return MOST_NEG;
      2: return '0;
      3: return $urandom_range(0, 1) ? UNITY : -UNITY;
      4: return W'($urandom_range(0, 2 * (1 << (F + 1)))) - W'(1 << (F + 1));
      5: return W'($urandom_range(0, 2 * (1 << F))) - W'(1 << F);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic op_t random_op();
    op_t op;
    op.a_re = pick_operand();
    op.a_im = pick_operand();
    op.b_re = pick_operand();
    op.b_im = pick_operand();
    op.power_exp = E'($urandom);
    case ($urandom_range(0, 19))
      0: op.cmd = CMD_TOP - CMD_BITS'($urandom_range(0, CMD_TOP - CMD_EQUAL - 1));
      default: op.cmd = CMD_BITS'($urandom_range(CMD_ADD, CMD_EQUAL));
    endcase
    // long powers are slow: mostly short exponents, a few up to the top
    if (op.cmd == CMD_POW && $urandom_range(0, 29) != 0)
      op.power_exp = E'($urandom_range(0, 9));
    if (op.cmd == CMD_DIV && $urandom_range(0, 7) == 0) begin
      op.b_re = '0;
      op.b_im = '0;
    end
    if (op.cmd == CMD_EQUAL && $urandom_range(0, 1) == 0) begin
      op.b_re = op.a_re;
      op.b_im = $urandom_range(0, 3) == 0 ? op.a_im ^ W'(1) : op.a_im;
    end
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts plus one long requested stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready   <= 1'b0;
    end else if (hold_rsp) begin
      hold_rsp    <= 1'b0;
      hold_cycles <= 400;
      rsp.ready   <= 1'b0;
    end else if (rsp_burst > 0) begin
      rsp_burst <= rsp_burst - 1;
      rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rsp_burst <= $urandom_range(0, 10);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic report(string what, logic [W-1:0] want, logic [W-1:0] got);
    $display("MISMATCH %s at %0t: expected %h got %h", what, $realtime, want, got);
    errors++;
  endtask

  // scoreboard: each accepted response against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", '0, rsp.res_re);
      end else begin
        want = pending_results.pop_front();
        if (rsp.res_re !== want.re) report("res_re", want.re, rsp.res_re);
        if (rsp.res_im !== want.im) report("res_im", want.im, rsp.res_im);
        if (rsp.flag !== want.flag) report("flag", W'(want.flag), W'(rsp.flag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // saturation of add/sub at both ends
    send_fields(CMD_ADD, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, '1);
    send_fields(CMD_SUB, MOST_NEG, MOST_POS, UNITY, -UNITY, '0);
    // mul: extremes, and (1+i)(1-i)
    send_fields(CMD_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, '0);
    send_fields(CMD_MUL, UNITY, UNITY, UNITY, -UNITY, '0);
    // div by zero raises flag; normal and overflowing quotients
    send_fields(CMD_DIV, MOST_POS, UNITY, '0, '0, '0);
    send_fields(CMD_DIV, UNITY, '0, '0, UNITY, '0);
    send_fields(CMD_DIV, MOST_NEG, MOST_POS, W'(1), '0, '0);
    send_fields(CMD_DIV, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, '0);
    // neg of the most negative word saturates
    send_fields(CMD_NEG, MOST_NEG, MOST_POS, '0, '0, '0);
    // pow: zero exponent, one, a few, and the longest
    send_fields(CMD_POW, MOST_NEG, MOST_NEG, '0, '0, '0);
    send_fields(CMD_POW, MOST_NEG, W'(5), '0, '0, E'(1));
    send_fields(CMD_POW, UNITY, UNITY, '0, '0, E'(3));
    send_fields(CMD_POW, UNITY, W'(1), '0, '0, '1);
    send_fields(CMD_POW, UNITY + W'(1000), UNITY, '0, '0, '1);
    // magnitude: saturating and exact
    send_fields(CMD_MAG, MOST_NEG, MOST_NEG, '0, '0, '0);
    send_fields(CMD_MAG, W'(3) << F, W'(-4) << F, '0, '0, '0);
    // sqrt: negative real, negative imaginary, extremes
    send_fields(CMD_SQRT, -UNITY, '0, '0, '0, '0);
    send_fields(CMD_SQRT, '0, W'(-2) << F, '0, '0, '0);
    send_fields(CMD_SQRT, MOST_NEG, MOST_NEG, '0, '0, '0);
    send_fields(CMD_SQRT, MOST_POS, MOST_POS, '0, '0, '0);
    // equality true and false
    send_fields(CMD_EQUAL, MOST_NEG, UNITY, MOST_NEG, UNITY, '0);
    send_fields(CMD_EQUAL, MOST_NEG, UNITY, MOST_NEG, UNITY + W'(1), '0);
    // unused opcodes give zero
    send_fields(CMD_EQUAL + CMD_BITS'(1), MOST_POS, MOST_POS, MOST_POS, MOST_POS, '1);
    send_fields(CMD_TOP, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, '1);
    drain_results();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_word(random_op());
  endtask

  // long receiver stall while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    hold_rsp = 1'b1;
    test_random(40);
    drain_results();
  endtask

  initial begin
    errors = 0;
    idle_on = 1'b0;
    hold_rsp = 1'b0;
    hold_cycles = 0;
    rsp_burst = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_ADD;
    req.a_re = '0;
    req.a_im = '0;
    req.b_re = '0;
    req.b_im = '0;
    req.power_exp = '0;
    rsp.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    idle_on = 1'b1;
    test_random(750);
    drain_results();
    test_backpressure();
    test_random(750);
    // final stretch: no idling on either side
    idle_on = 1'b0;
    test_random(350);
    drain_results();

    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
